[src/dcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dcd_pkg;

   // field widths
   localparam int ATTR_W_MAX  = 64;
   localparam int CLASS_W     = 8;
   localparam int PRIOR_W     = 11;
   localparam int CONF_W      = 12;
   localparam int STORED_W    = 11;
   localparam int VERDICT_W   = 2;

   // parameter defaults
   localparam int DEPTH_DEFAULT      = 1024;
   localparam int ATTR_WIDTH_DEFAULT = 64;

   // function codes
   localparam logic FUNC_CHECK = 1'b0;
   localparam logic FUNC_ADD   = 1'b1;

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_DISTINCT     = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_INCONSISTENT = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE    = 2'd2;

   // conflict count saturation
   localparam logic [CONF_W-1:0] CONF_MAX = {CONF_W{1'b1}};

   // word traveling down the cell chain
   typedef struct packed {
      logic                  valid;
      logic                  func;
      logic [ATTR_W_MAX-1:0] attributes;
      logic [CLASS_W-1:0]    class_label;
      logic [CONF_W-1:0]     conflicts;
      logic                  dup;
      logic                  full;
      logic [STORED_W-1:0]   stored;
   } token_type;

endpackage

`default_nettype wire

[src/dcd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dcd_req_if;
   import dcd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [ATTR_W_MAX-1:0] attributes;
   logic [CLASS_W-1:0]    class_label;
   logic [PRIOR_W-1:0]    prior_conflicts;

   modport source (output valid, output func, output attributes, output class_label,
                   output prior_conflicts, input ready);
   modport sink   (input valid, input func, input attributes, input class_label,
                   input prior_conflicts, output ready);
endinterface

interface dcd_rsp_if;
   import dcd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;
   logic [CONF_W-1:0]    conflict_count;
   logic [STORED_W-1:0]  stored_count;
   logic                 table_full;

   modport source (output valid, output verdict, output conflict_count,
                   output stored_count, output table_full, input ready);
   modport sink   (input valid, input verdict, input conflict_count,
                   input stored_count, input table_full, output ready);
endinterface

`default_nettype wire

[src/dcd_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module dcd_cell #(
   parameter  int DEPTH      = dcd_pkg::DEPTH_DEFAULT,
   parameter  int ATTR_WIDTH = dcd_pkg::ATTR_WIDTH_DEFAULT,
   parameter  int INDEX      = 0,
   localparam int CNT_W      = $clog2(DEPTH + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      wr_en,
   input  wire logic [CNT_W-1:0]          wr_index,
   input  wire logic [ATTR_WIDTH-1:0]     wr_attr,
   input  wire logic [dcd_pkg::CLASS_W-1:0] wr_class,
   input  wire dcd_pkg::token_type        tok_in,
   input  wire logic [CNT_W-1:0]          lim_in,
   output dcd_pkg::token_type             tok_out,
   output logic [CNT_W-1:0]               lim_out
);
   import dcd_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [ATTR_WIDTH-1:0] entry_attr_ff;
   logic [CLASS_W-1:0]    entry_class_ff;
   token_type             tok_ff, tok_in_w;
   logic [CNT_W-1:0]      lim_ff;
   logic                  hit;

   // stored entry, written when the append pointer lands here
   always_ff @(posedge clock) begin
      if (wr_en && wr_index == MY_INDEX) begin
         entry_attr_ff  <= wr_attr;
         entry_class_ff <= wr_class;
      end
   end

   // only entries older than the word's snapshot take part
   assign hit = tok_in.valid && tok_in.func == FUNC_CHECK && !tok_in.dup &&
                MY_INDEX < lim_in &&
                entry_attr_ff == tok_in.attributes[ATTR_WIDTH-1:0];

   always_comb begin
      tok_in_w = tok_in;
      if (hit) begin
         if (entry_class_ff == tok_in.class_label) begin
            tok_in_w.dup = 1'b1;
         end else if (tok_in.conflicts != CONF_MAX) begin
            tok_in_w.conflicts = tok_in.conflicts + CONF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_w;
         lim_ff <= lim_in;
      end
   end

   assign tok_out = tok_ff;
   assign lim_out = lim_ff;

endmodule

`default_nettype wire

[src/duplicate_conflict_detector_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Duplicate / conflict detector.
// req_chan carries one word per observation: func selects check or add.
// rsp_chan returns exactly one word per request, in request order.
// Storage is a chain of DEPTH cells, one stored entry per cell. Every
// request travels the whole chain, one cell per cycle while it advances;
// a check compares against each cell it passes. Unless the receiver stalls,
// a new request is taken every cycle: throughput is one word per cycle,
// set by the cell chain advancing one stage per clock.
// An add writes its cell at acceptance; each request carries a snapshot of
// the entry count, so later adds never leak into earlier checks.
// Reset (synchronous, active high) empties the table and the chain; stored
// entries themselves are not cleared, the count guards them.
// When the receiver stalls the chain freezes and req_chan.ready drops; the
// output register holds its word until taken.
module duplicate_conflict_detector_top #(
   parameter int DEPTH      = dcd_pkg::DEPTH_DEFAULT,
   parameter int ATTR_WIDTH = dcd_pkg::ATTR_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   dcd_req_if.sink   req_chan,
   dcd_rsp_if.source rsp_chan
);
   import dcd_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [ATTR_W_MAX-1:0] ATTR_MASK =
      {ATTR_W_MAX{1'b1}} >> (ATTR_W_MAX - ATTR_WIDTH);

   token_type            tok [DEPTH+1];
   logic [CNT_W-1:0]     lim [DEPTH+1];

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 advance, accept, is_add, is_full, wr_en;

   logic                 out_valid_ff;
   logic [VERDICT_W-1:0] out_verdict_ff, out_verdict_in;
   logic [CONF_W-1:0]    out_conf_ff;
   logic [STORED_W-1:0]  out_stored_ff;
   logic                 out_full_ff;

   // chain moves whenever the output register is free or being drained
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   assign is_add  = req_chan.func == FUNC_ADD;
   assign is_full = count_ff == CNT_W'(DEPTH);
   assign wr_en   = accept && is_add && !is_full;

   // entry count after this word
   assign count_in = wr_en ? count_ff + CNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // head of the chain: the incoming word, masked and prepared
   always_comb begin
      tok[0].valid       = accept;
      tok[0].func        = req_chan.func;
      tok[0].attributes  = req_chan.attributes & ATTR_MASK;
      tok[0].class_label = req_chan.class_label;
      tok[0].conflicts   = is_add ? '0 : CONF_W'(req_chan.prior_conflicts);
      tok[0].dup         = 1'b0;
      tok[0].full        = is_add && is_full;
      tok[0].stored      = STORED_W'(count_in);
   end
   assign lim[0] = count_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      dcd_cell #(
         .DEPTH      (DEPTH),
         .ATTR_WIDTH (ATTR_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .wr_en    (wr_en),
         .wr_index (count_ff),
         .wr_attr  (req_chan.attributes[ATTR_WIDTH-1:0]),
         .wr_class (req_chan.class_label),
         .tok_in   (tok[i]),
         .lim_in   (lim[i]),
         .tok_out  (tok[i+1]),
         .lim_out  (lim[i+1])
      );
   end

   // verdict from the finished word
   always_comb begin
      if (tok[DEPTH].func == FUNC_ADD) begin
         out_verdict_in = VERDICT_DISTINCT;
      end else if (tok[DEPTH].dup) begin
         out_verdict_in = VERDICT_DUPLICATE;
      end else if (tok[DEPTH].conflicts != '0) begin
         out_verdict_in = VERDICT_INCONSISTENT;
      end else begin
         out_verdict_in = VERDICT_DISTINCT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= tok[DEPTH].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_verdict_ff <= out_verdict_in;
         out_conf_ff    <= tok[DEPTH].conflicts;
         out_stored_ff  <= tok[DEPTH].stored;
         out_full_ff    <= tok[DEPTH].full;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.verdict        = out_verdict_ff;
   assign rsp_chan.conflict_count = out_conf_ff;
   assign rsp_chan.stored_count   = out_stored_ff;
   assign rsp_chan.table_full     = out_full_ff;

   // count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond table size");

   // dropped add leaves the table alone
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && is_add && is_full) |=> $stable(count_ff))
      else $error("entry count moved on a dropped add");

   // accepted add with room bumps the count by one
   a_add_bump: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not advance entry count");

   // stall freezes the chain tail
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tok[DEPTH].valid))
      else $error("chain moved while output stalled");

   // dropped add reports a clean verdict
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.table_full) |->
      (rsp_chan.verdict == VERDICT_DISTINCT && rsp_chan.conflict_count == '0))
      else $error("table full word carries a check result");

endmodule

`default_nettype wire
